@@ src/assert_macros.svh @@
// Assertion macros used by the hash table core to check the design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset
`define OAHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Same check with a caller supplied message
`define OAHT_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

@@ src/oaht_pkg.sv @@
// Types, constants and codes of the open address hash table
package oaht_pkg;

  localparam int CAPACITY   = 1024;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = SLOT_BITS + 1;
  localparam int KEY_BITS   = 32;
  localparam int KEY_PORT_BITS = 32;

  localparam logic [COUNT_BITS-1:0] FILL_LIMIT_RESET = COUNT_BITS'(512);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SLOT_ZERO = 2'd0,
    SLOT_HIT  = 2'd1,
    SLOT_FREE = 2'd2
  } slot_sel_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_READ  = 2'd2,
    S_CHECK = 2'd3
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      clear_step;
    logic      load;
    logic      rd;
    logic      advance;
    logic      wr_insert;
    logic      wr_delete;
    logic      emit;
    status_e   status;
    slot_sel_e slot_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic  clear_last;
    op_e   op;
    mark_e mark;
    logic  key_eq;
    logic  last_probe;
    logic  have_free;
    logic  full;
  } dp_sts_t;

endpackage

@@ src/oaht_ctrl.sv @@
// Controller state machine: clearing pass, probe sequencing, result decision
module oaht_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  oaht_pkg::dp_sts_t sts_i,
  output oaht_pkg::dp_cmd_t cmd_o
);
  import oaht_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.mark == MARK_USED && sts_i.key_eq) begin
          // Hit: report or remove
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          if (sts_i.op == OP_DELETE) begin
            cmd_o.wr_delete = 1'b1;
            cmd_o.status    = ST_DELETED;
            cmd_o.slot_sel  = SLOT_ZERO;
          end else begin
            cmd_o.status   = ST_FOUND;
            cmd_o.slot_sel = SLOT_HIT;
          end
        end else if (sts_i.mark == MARK_EMPTY || sts_i.last_probe) begin
          // Miss: insert at the first free slot seen, if allowed
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          if (sts_i.op == OP_INSERT) begin
            if (!sts_i.full && sts_i.have_free) begin
              cmd_o.wr_insert = 1'b1;
              cmd_o.status    = ST_INSERTED;
              cmd_o.slot_sel  = SLOT_FREE;
            end else begin
              cmd_o.status   = ST_FULL;
              cmd_o.slot_sel = SLOT_ZERO;
            end
          end else begin
            cmd_o.status   = ST_NOT_FOUND;
            cmd_o.slot_sel = SLOT_ZERO;
          end
        end else begin
          // Keep probing
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ src/oaht_dpath.sv @@
// Datapath: key and mark memories, probe address, counters and result registers
module oaht_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  oaht_pkg::dp_cmd_t                    cmd_i,
  output oaht_pkg::dp_sts_t                    sts_o,
  input  logic [1:0]                           operation_i,
  input  logic [oaht_pkg::KEY_PORT_BITS-1:0]   key_i,
  input  logic                                 cfg_we_i,
  input  logic [oaht_pkg::COUNT_BITS-1:0]      cfg_wdata_i,
  output logic                                 done_o,
  output logic [2:0]                           status_o,
  output logic [oaht_pkg::SLOT_BITS-1:0]       slot_o,
  output logic [oaht_pkg::COUNT_BITS-1:0]      entries_held_o
);
  import oaht_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  mark_e                 mark_mem [CAPACITY];

  logic [KEY_BITS-1:0]   key_q, key_rd_q;
  mark_e                 mark_rd_q;
  op_e                   op_q, op_dec;
  logic [SLOT_BITS-1:0]  pos_q, inc_q, cnt_q, free_pos_q;
  logic                  have_free_q;
  logic [COUNT_BITS-1:0] live_q, live_d, fill_q;
  logic                  done_q;
  status_e               status_q;
  logic [SLOT_BITS-1:0]  slot_q, slot_d;
  logic [COUNT_BITS-1:0] held_q;

  logic                  hf_now;
  logic [SLOT_BITS-1:0]  fp_now;
  logic                  mark_we;
  logic [SLOT_BITS-1:0]  mark_wa;
  mark_e                 mark_wd;

  // Decode the operation; the spare code acts as a lookup
  always_comb begin
    unique case (operation_i)
      OP_INSERT: op_dec = OP_INSERT;
      OP_DELETE: op_dec = OP_DELETE;
      default:   op_dec = OP_LOOKUP;
    endcase
  end

  // Free slot seen so far, including the slot under test
  assign hf_now = have_free_q || (mark_rd_q != MARK_USED);
  assign fp_now = have_free_q ? free_pos_q : pos_q;

  // Item and probe registers; pos_q doubles as the clearing address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      inc_q       <= '0;
      cnt_q       <= '0;
      have_free_q <= 1'b0;
      free_pos_q  <= '0;
      op_q        <= OP_LOOKUP;
    end else if (cmd_i.clear_step) begin
      pos_q <= pos_q + SLOT_BITS'(1);
    end else if (cmd_i.load) begin
      pos_q       <= key_i[SLOT_BITS-1:0];
      inc_q       <= SLOT_BITS'(1);
      cnt_q       <= '0;
      have_free_q <= 1'b0;
      free_pos_q  <= '0;
      op_q        <= op_dec;
    end else if (cmd_i.advance) begin
      // Step to home + (i+1)^2 by adding 2i+1
      pos_q       <= pos_q + inc_q;
      inc_q       <= inc_q + SLOT_BITS'(2);
      cnt_q       <= cnt_q + SLOT_BITS'(1);
      have_free_q <= hf_now;
      free_pos_q  <= fp_now;
    end
  end

  // Hold the key of the current beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i[KEY_BITS-1:0];
    end
  end

  // Registered memory read at the probe address
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      key_rd_q  <= key_mem[pos_q];
      mark_rd_q <= mark_mem[pos_q];
    end
  end

  // Mark writes: clearing pass, insert, delete
  assign mark_we = cmd_i.clear_step || cmd_i.wr_insert || cmd_i.wr_delete;
  assign mark_wa = cmd_i.wr_insert ? fp_now : pos_q;
  always_comb begin
    if (cmd_i.wr_insert) begin
      mark_wd = MARK_USED;
    end else if (cmd_i.wr_delete) begin
      mark_wd = MARK_DELETED;
    end else begin
      mark_wd = MARK_EMPTY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_insert) begin
      key_mem[fp_now] <= key_q;
    end
  end

  // Live entry count after this beat
  always_comb begin
    live_d = live_q;
    if (cmd_i.wr_insert) begin
      live_d = live_q + COUNT_BITS'(1);
    end else if (cmd_i.wr_delete && live_q != '0) begin
      live_d = live_q - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      fill_q <= FILL_LIMIT_RESET;
    end else begin
      live_q <= live_d;
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
    end
  end

  // Result slot select
  always_comb begin
    unique case (cmd_i.slot_sel)
      SLOT_HIT:  slot_d = pos_q;
      SLOT_FREE: slot_d = fp_now;
      default:   slot_d = '0;
    endcase
  end

  // Result registers, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      slot_q   <= slot_d;
      held_q   <= live_d;
    end
  end

  // Status to the controller
  assign sts_o.clear_last = (pos_q == SLOT_BITS'(CAPACITY - 1));
  assign sts_o.op         = op_q;
  assign sts_o.mark       = mark_rd_q;
  assign sts_o.key_eq     = (key_rd_q == key_q);
  assign sts_o.last_probe = (cnt_q == SLOT_BITS'(CAPACITY - 1));
  assign sts_o.have_free  = hf_now;
  assign sts_o.full       = (live_q >= fill_q);

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign entries_held_o = held_q;

endmodule

@@ src/open_address_hash_table_core.sv @@
// A beat is taken on start while idle; each probe then takes one memory read and one check,
// and the result is registered after the last check. A new beat is taken once busy is low again.
// After reset the mark memory is cleared, one slot per cycle, over all 1024 slots (busy high).
// The fill limit resets to 512; config writes are taken in any cycle.
// Results are strobed by done_o for one cycle; the receiver cannot stall them.
module open_address_hash_table_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation_i,
  input  logic [oaht_pkg::KEY_PORT_BITS-1:0]   key_i,
  input  logic                                 cfg_we_i,
  input  logic [oaht_pkg::COUNT_BITS-1:0]      cfg_wdata_i,
  output logic                                 done_o,
  output logic [2:0]                           status_o,
  output logic [oaht_pkg::SLOT_BITS-1:0]       slot_o,
  output logic [oaht_pkg::COUNT_BITS-1:0]      entries_held_o
);
  import oaht_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    slotless_status;

  // Sequence the probes
  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Store and compare
  oaht_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entries_held_o (entries_held_o)
  );

  // Statuses that carry no slot
  assign slotless_status = (status_o == ST_DELETED) || (status_o == ST_NOT_FOUND) ||
                           (status_o == ST_FULL);

  // A result only follows work in progress
  `OAHT_ASSERT(a_done_after_busy, done_o |-> $past(busy))
  // An accepted beat starts work
  `OAHT_ASSERT(a_start_busy, (start && !busy) |=> busy)
  // Insert and delete never write in the same cycle
  `OAHT_ASSERT_MSG(a_one_write, !(cmd.wr_insert && cmd.wr_delete), "double write")
  // Results without a slot report zero
  `OAHT_ASSERT(a_slot_zero, (done_o && slotless_status) |-> (slot_o == '0))
  // An insert leaves at least one live entry
  `OAHT_ASSERT(a_ins_live, (done_o && status_o == ST_INSERTED) |-> (entries_held_o != '0))

endmodule

@@ tb/oaht_table_checker.sv @@
// Shadow hash table that predicts and checks every reply of the hash table core
module oaht_table_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [1:0]                         operation_i,
  input  logic [oaht_pkg::KEY_PORT_BITS-1:0] key_i,
  input  logic                               cfg_we_i,
  input  logic [oaht_pkg::COUNT_BITS-1:0]    cfg_wdata_i,
  input  logic                               done_i,
  input  logic [2:0]                         status_i,
  input  logic [oaht_pkg::SLOT_BITS-1:0]     slot_i,
  input  logic [oaht_pkg::COUNT_BITS-1:0]    entries_held_i,
  output int unsigned                        pending_o,
  output int unsigned                        mismatches_o,
  output int unsigned                        replies_o,
  output int unsigned                        refusals_o
);
  import oaht_pkg::*;

  typedef struct packed {
    status_e               status;
    logic [SLOT_BITS-1:0]  slot;
    logic [COUNT_BITS-1:0] held;
  } reply_t;

  // Shadow copy of the table, the live count and the fill limit
  logic [KEY_BITS-1:0]   shadow_key [CAPACITY];
  mark_e                 shadow_mark [CAPACITY];
  logic [COUNT_BITS-1:0] shadow_live;
  logic [COUNT_BITS-1:0] shadow_limit;

  reply_t      expected_replies [$];
  reply_t      want;
  int unsigned mismatch_count = 0;
  int unsigned reply_count = 0;
  int unsigned refusal_count = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: reply %0d mismatch: %s", $time, reply_count, msg);
    end
  endtask

  // Walk the quadratic probe path: stop on a matching used slot or an empty one,
  // and remember the first empty or deleted slot passed on the way
  function automatic void search_slot(input logic [KEY_BITS-1:0] key,
                                      output logic found,
                                      output logic [SLOT_BITS-1:0] hit,
                                      output logic have_free,
                                      output logic [SLOT_BITS-1:0] free_slot);
    int unsigned home;
    int unsigned pos;
    home      = key % CAPACITY;
    found     = 1'b0;
    hit       = '0;
    have_free = 1'b0;
    free_slot = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      pos = (home + i * i) % CAPACITY;
      if (shadow_mark[pos] == MARK_USED) begin
        if (shadow_key[pos] == key) begin
          found = 1'b1;
          hit   = pos[SLOT_BITS-1:0];
          return;
        end
      end else begin
        if (!have_free) begin
          have_free = 1'b1;
          free_slot = pos[SLOT_BITS-1:0];
        end
        if (shadow_mark[pos] == MARK_EMPTY) return;
      end
    end
  endfunction

  // Apply one command to the shadow table and return the reply it must give
  function automatic reply_t table_apply(input logic [1:0] op,
                                         input logic [KEY_BITS-1:0] key);
    reply_t r;
    logic found;
    logic have_free;
    logic [SLOT_BITS-1:0] hit;
    logic [SLOT_BITS-1:0] free_slot;
    search_slot(key, found, hit, have_free, free_slot);
    r.slot = '0;
    if (op == OP_DELETE) begin
      if (found) begin
        shadow_mark[hit] = MARK_DELETED;
        if (shadow_live != '0) shadow_live = shadow_live - COUNT_BITS'(1);
        r.status = ST_DELETED;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else if (found) begin
      r.status = ST_FOUND;
      r.slot   = hit;
    end else if (op == OP_INSERT) begin
      if (shadow_live >= shadow_limit || !have_free) begin
        r.status = ST_FULL;
      end else begin
        shadow_key[free_slot]  = key;
        shadow_mark[free_slot] = MARK_USED;
        shadow_live            = shadow_live + COUNT_BITS'(1);
        r.status               = ST_INSERTED;
        r.slot                 = free_slot;
      end
    end else begin
      // plain lookup, and the spare operation code behaves the same
      r.status = ST_NOT_FOUND;
    end
    r.held = shadow_live;
    return r;
  endfunction

  // Check replies against the oldest prediction, then take config and command beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CAPACITY; s++) begin
        shadow_mark[s] = MARK_EMPTY;
        shadow_key[s]  = '0;
      end
      shadow_live  = '0;
      shadow_limit = FILL_LIMIT_RESET;
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      // a reply always belongs to a beat taken at an earlier edge
      if (done_i) begin
        reply_count++;
        if (status_i == ST_FULL) refusal_count++;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply with no command waiting (status %0d)", status_i));
        end else begin
          want = expected_replies.pop_front();
          if (status_i !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d", status_i, want.status));
          end
          if (slot_i !== want.slot) begin
            report_mismatch($sformatf("slot got %0d expected %0d", slot_i, want.slot));
          end
          if (entries_held_i !== want.held) begin
            report_mismatch($sformatf("entries_held got %0d expected %0d",
                                      entries_held_i, want.held));
          end
        end
      end
      if (cfg_we_i) shadow_limit = cfg_wdata_i;
      if (start_i && !busy_i) begin
        expected_replies.push_back(table_apply(operation_i, key_i[KEY_BITS-1:0]));
      end
      pending_o <= expected_replies.size();
    end
    mismatches_o <= mismatch_count;
    replies_o    <= reply_count;
    refusals_o   <= refusal_count;
  end

endmodule

@@ tb/tb_open_address_hash_table_core.sv @@
// Stimulus and verdict for the open address hash table core
module tb_open_address_hash_table_core;
  import oaht_pkg::*;

  localparam logic [1:0]  OP_SPARE      = 2'd3;
  localparam int unsigned MAX_GAP       = 8;
  localparam int unsigned MAX_BURST     = 16;
  localparam int unsigned LONG_BURST    = 60;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CHAIN_HOME    = 7;
  localparam int unsigned CHAIN_KEYS    = 176;
  localparam int unsigned POOL_DEPTH    = 128;
  localparam int unsigned NUM_HOMES     = 6;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_BEATS   = 210;
  localparam int unsigned BEAT_BUDGET   = 1400;
  localparam int unsigned DRAIN_CYCLES  = 2 * CAPACITY + 4;
  // every beat at the longest probe path plus the longest gap, clear pass, drains
  localparam int unsigned CYCLE_LIMIT   =
    3 * (BEAT_BUDGET * (2 * CAPACITY + 3 + MAX_GAP) + CAPACITY + 64 * (DRAIN_CYCLES + 8));

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               operation_i = 2'd0;
  logic [KEY_PORT_BITS-1:0] key_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [COUNT_BITS-1:0]    cfg_wdata_i = '0;
  logic                     done_o;
  logic [2:0]               status_o;
  logic [SLOT_BITS-1:0]     slot_o;
  logic [COUNT_BITS-1:0]    entries_held_o;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned replies;
  int unsigned refusals;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned limit_writes = 0;
  int unsigned burst_left = 0;

  logic [KEY_PORT_BITS-1:0] key_pool [$];
  logic [SLOT_BITS-1:0]     cluster_home [NUM_HOMES];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  open_address_hash_table_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .entries_held_o (entries_held_o)
  );

  oaht_table_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .slot_i         (slot_o),
    .entries_held_i (entries_held_o),
    .pending_o      (pending),
    .mismatches_o   (mismatches),
    .replies_o      (replies),
    .refusals_o     (refusals)
  );

  // Drop start and hold off for a number of cycles
  task automatic idle(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Present one command beat and hold it until the core takes it; start stays high
  task automatic send_beat(input logic [1:0] op, input logic [KEY_PORT_BITS-1:0] key);
    start       <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    do @(posedge clk_i); while (busy);
    beats_sent++;
    if (op == OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
    // advance the burst pattern: random bursts, mostly with a gap after them
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? LONG_BURST : $urandom_range(1, MAX_BURST);
      if ($urandom_range(0, 9) >= 3) idle($urandom_range(1, MAX_GAP));
    end
  endtask

  // Wait until every reply is back, then write the fill limit
  task automatic set_fill_limit(input logic [COUNT_BITS-1:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [KEY_PORT_BITS-1:0] chain_key(input int unsigned idx);
    return KEY_PORT_BITS'(CHAIN_HOME + CAPACITY * idx);
  endfunction

  // Nearly half keys already inserted, some colliding on a few homes, the rest fully random
  function automatic logic [KEY_PORT_BITS-1:0] pick_key();
    int unsigned roll;
    logic [KEY_PORT_BITS-1:0] k;
    roll = $urandom_range(0, 99);
    k    = $urandom();
    if (roll < 45 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (roll < 70) begin
      k[SLOT_BITS-1:0] = cluster_home[$urandom_range(0, NUM_HOMES - 1)];
    end
    return k;
  endfunction

  function automatic logic [1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return OP_INSERT;
    if (roll < 65) return OP_LOOKUP;
    if (roll < 93) return OP_DELETE;
    return OP_SPARE;
  endfunction

  initial begin : stimulus
    int unsigned lim;
    for (int h = 0; h < NUM_HOMES; h++) begin
      cluster_home[h] = SLOT_BITS'($urandom_range(0, CAPACITY - 1));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, collisions, tombstones, duplicates, spare op code
    send_beat(OP_LOOKUP, 32'd0);
    send_beat(OP_INSERT, 32'd0);
    send_beat(OP_INSERT, 32'hFFFF_FFFF);
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 32'd0);
    send_beat(OP_INSERT, 32'd1024);
    send_beat(OP_INSERT, 32'd2048);
    send_beat(OP_DELETE, 32'd1024);
    send_beat(OP_LOOKUP, 32'd2048);
    send_beat(OP_LOOKUP, 32'd1024);
    send_beat(OP_INSERT, 32'd3072);
    send_beat(OP_DELETE, 32'd5);
    send_beat(OP_SPARE, 32'd0);
    send_beat(OP_SPARE, 32'd7);
    send_beat(OP_DELETE, 32'd0);
    send_beat(OP_LOOKUP, 32'd0);
    send_beat(OP_INSERT, 32'hAAAA_AAAA);
    send_beat(OP_INSERT, 32'h5555_5555);

    // Fill limit of zero refuses every insert; lookups and deletes still work
    set_fill_limit('0);
    send_beat(OP_INSERT, 32'd123);
    send_beat(OP_LOOKUP, 32'd2048);
    send_beat(OP_DELETE, 32'd2048);

    // Small limit: two inserts pass, the third hits the limit
    set_fill_limit(COUNT_BITS'(6));
    send_beat(OP_INSERT, 32'd10);
    send_beat(OP_INSERT, 32'd11);
    send_beat(OP_INSERT, 32'd12);

    // Saturate one probe path so inserts run out of free slots below the limit
    set_fill_limit(COUNT_BITS'(CAPACITY));
    for (int unsigned j = 0; j < CHAIN_KEYS; j++) send_beat(OP_INSERT, chain_key(j));
    send_beat(OP_LOOKUP, chain_key(CHAIN_KEYS + 300));
    send_beat(OP_SPARE, chain_key(CHAIN_KEYS + 301));
    send_beat(OP_DELETE, chain_key(5));
    send_beat(OP_DELETE, chain_key(9));
    send_beat(OP_LOOKUP, chain_key(100));
    send_beat(OP_INSERT, chain_key(CHAIN_KEYS + 302));
    send_beat(OP_INSERT, chain_key(CHAIN_KEYS + 303));
    send_beat(OP_INSERT, chain_key(CHAIN_KEYS + 304));

    // Random phases, each under its own fill limit
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: lim = CAPACITY;
        1: lim = 200;
        2: lim = $urandom_range(0, CAPACITY);
        3: lim = 700;
        default: lim = CAPACITY - 1;
      endcase
      set_fill_limit(COUNT_BITS'(lim));
      for (int unsigned n = 0; n < PHASE_BEATS; n++) send_beat(pick_op(), pick_key());
    end

    // Drain, then watch for stray replies
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d command beats over %0d fill limit writes, incl. a saturated probe path",
             beats_sent, limit_writes);
    $display("checked %0d replies, %0d refused as table full", replies, refusals);
    if (mismatches == 0) begin
      $display("open_address_hash_table_core test passed");
    end else begin
      $display("open_address_hash_table_core test failed");
    end
    $finish;
  end

  // End the run if the core stops answering
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("open_address_hash_table_core test failed");
    $finish;
  end

endmodule
